/* rtl/lkrc_pkg.sv */
// ----------------------------------------------------------------------------
// lkrc_pkg
// Shared widths, constants and arithmetic helpers for the Lehmer keystream
// rotation cipher: generator step mod 65537 and printable byte rotation.
// ----------------------------------------------------------------------------
package lkrc_pkg;

    localparam int unsigned SeedW  = 17;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned KeyW   = 7;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 17;

    localparam logic [SeedW-1:0] SeedReset = 17'd1;
    localparam logic [23:0]      Mult      = 24'd75;
    localparam logic [SeedW-1:0] Modulus   = 17'h10001;
    localparam logic [7:0]       Span      = 8'd96;
    localparam logic [6:0]       FirstPrint = 7'd32;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_INITIAL_SEED = 1'b0,
        CFG_DECRYPT_MODE = 1'b1
    } t_cfg_idx;

    // seed * 75 mod 65537 by low-minus-high split
    function automatic logic [SeedW-1:0] advance_seed(input logic [SeedW-1:0] s);
        logic [23:0] p;
        logic [15:0] lo;
        logic [7:0]  hi;
        p  = {7'd0, s} * Mult;
        lo = p[15:0];
        hi = p[23:16];
        if (lo >= {8'd0, hi}) begin
            return {1'b0, lo} - {9'd0, hi};
        end else begin
            return {1'b0, lo} + Modulus - {9'd0, hi};
        end
    endfunction

    // r mod 96 as (r>>5 mod 3)*32 + r[4:0]
    function automatic logic [KeyW-1:0] key_of(input logic [SeedW-1:0] r);
        logic [4:0] dsum;
        logic [2:0] fold;
        logic [1:0] m3;
        dsum = {3'd0, r[6:5]} + {3'd0, r[8:7]} + {3'd0, r[10:9]}
             + {3'd0, r[12:11]} + {3'd0, r[14:13]} + {3'd0, r[16:15]};
        fold = {1'b0, dsum[1:0]} + {1'b0, dsum[3:2]} + {2'd0, dsum[4]};
        if (fold >= 3'd6) begin
            fold = fold - 3'd6;
        end else if (fold >= 3'd3) begin
            fold = fold - 3'd3;
        end
        m3 = fold[1:0];
        return {m3, r[4:0]};
    endfunction

    // rotate 32..127 by k, pass everything else
    function automatic logic [ByteW-1:0] rotate_byte(
        input logic [ByteW-1:0] b,
        input logic [KeyW-1:0]  k,
        input logic             backward
    );
        logic [6:0] off;
        logic [7:0] t;
        logic [6:0] res;
        off = b[6:0] - FirstPrint;
        if (backward) begin
            t = {1'b0, off} + Span - {1'b0, k};
        end else begin
            t = {1'b0, off} + {1'b0, k};
        end
        if (t >= Span) begin
            t = t - Span;
        end
        res = t[6:0] + FirstPrint;
        if (b[7] || (b[6:5] == 2'b00)) begin
            return b;
        end else begin
            return {1'b0, res};
        end
    endfunction

endpackage

/* rtl/lehmer_keystream_rotation_cipher.sv */
// ----------------------------------------------------------------------------
// lehmer_keystream_rotation_cipher
// Byte stream cipher: a Lehmer generator mod 65537 steps on each accepted byte
// bar a config write; its value mod 96 rotates printable bytes forward or back.
// ----------------------------------------------------------------------------
// pipeline: an accepted item is registered in the input stage and then in the
// result stage
// throughput: one item per cycle while not stalled by i_stall; the generator
// step is the only loop, closed through a constant multiply and subtract
// reset (synchronous, active low): seed 1, encrypt mode, pipeline empty
// ----------------------------------------------------------------------------
module lehmer_keystream_rotation_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [lkrc_pkg::ByteW-1:0]          i_byte_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [lkrc_pkg::ByteW-1:0]          o_byte_out,
    input  logic                                i_cfg_we,
    input  logic [lkrc_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [lkrc_pkg::CfgDataW-1:0]       i_cfg_data
);

    logic [lkrc_pkg::SeedW-1:0] r_seed;
    logic [lkrc_pkg::SeedW-1:0] n_seed;
    logic                       r_decrypt;

    logic                       r_mid_vld;
    logic [lkrc_pkg::ByteW-1:0] r_mid_byte;
    logic [lkrc_pkg::SeedW-1:0] r_mid_seed;

    logic                       r_out_vld;
    logic [lkrc_pkg::ByteW-1:0] r_out_byte;

    logic out_adv;
    logic mid_adv;
    logic in_acc;

    assign out_adv = !r_out_vld || !i_stall;
    assign mid_adv = !r_mid_vld || out_adv;
    assign o_stall = !mid_adv;
    assign in_acc  = i_valid && mid_adv;
    assign n_seed  = lkrc_pkg::advance_seed(r_seed);

    assign o_valid    = r_out_vld;
    assign o_byte_out = r_out_byte;

    // generator and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= lkrc_pkg::SeedReset;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (lkrc_pkg::t_cfg_idx'(i_cfg_idx))
                lkrc_pkg::CFG_INITIAL_SEED: r_seed    <= i_cfg_data;
                lkrc_pkg::CFG_DECRYPT_MODE: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end else if (in_acc) begin
            r_seed <= n_seed;
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else if (mid_adv) begin
            r_mid_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mid_byte <= i_byte_in;
            r_mid_seed <= n_seed;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_mid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_mid_vld) begin
            r_out_byte <= lkrc_pkg::rotate_byte(r_mid_byte,
                                                lkrc_pkg::key_of(r_mid_seed),
                                                r_decrypt);
        end
    end

endmodule
